/* src/csvtr_pkg.sv */
// types, constants and helpers shared by the trade record line parser
`timescale 1ns / 1ps

package csvtr_pkg;

  // input item: one byte of the line and its end marker
  typedef struct packed {
    logic [7:0] line_byte;
    logic       end_of_line;
  } in_item_t;

  // result status codes, lowest applicable code wins
  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_FIELDS     = 3'd1,
    STAT_BAD_PRICE  = 3'd2,
    STAT_BAD_QTY    = 3'd3,
    STAT_BAD_SIDE   = 3'd4,
    STAT_SYMBOL_LONG = 3'd5
  } status_t;

  // result item for one line
  typedef struct packed {
    status_t            status;
    logic [63:0]        symbol_text;
    logic [3:0]         symbol_length;
    logic signed [63:0] price_ticks;
    logic [31:0]        quantity;
    logic [7:0]         side_code;
  } out_item_t;

  // configuration register map
  localparam logic [2:0] ADDR_FIELD_SEP = 3'd0;
  localparam logic [7:0] FIELD_SEP_RESET = 8'd44;

  // character codes
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // field numbering, counts separators and saturates at four
  localparam logic [2:0] FIELD_SYMBOL = 3'd0;
  localparam logic [2:0] FIELD_PRICE  = 3'd1;
  localparam logic [2:0] FIELD_QTY    = 3'd2;
  localparam logic [2:0] FIELD_SIDE   = 3'd3;
  localparam logic [2:0] FIELD_MAX    = 3'd4;

  // magnitude of the most negative int64
  localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;

  // largest accumulator that still takes digit d: (MAG_LIMIT - d) / 10
  function automatic logic [63:0] digit_limit(input logic [3:0] d);
    logic [63:0] lim;
    if (d == 4'd9) begin
      lim = 64'd922337203685477579;
    end else begin
      lim = 64'd922337203685477580;
    end
    return lim;
  endfunction

endpackage

/* src/csv_trade_record_parser.sv */
// Trade record line parser: takes one byte item per clock while in_stall
// is low and splits each line on the separator byte into symbol, price,
// quantity and side, giving one result item when the byte marked end of
// line has been taken. Bytes are accepted at one per cycle back to back
// while in_stall is low; out_valid rises once the end-of-line byte has
// passed the input register and the line state update has loaded the
// result register from it. The per-byte loop closes in the line state
// update, whose longest path is the decimal multiply-by-ten add and the
// int64 overflow compare. Only an end-of-line byte waits on a stalled
// result register; other bytes keep flowing. Symbols keep their first
// SYMBOL_BYTES bytes (1 to 8). The separator register sits at byte
// address 0 of the APB-style port (also decoded at 1 to 3) and resets to
// a comma.
`timescale 1ns / 1ps

module csv_trade_record_parser
  import csvtr_pkg::*;
#(
  parameter int SYMBOL_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0] field_sep_r;
  logic       stg_valid;
  in_item_t   stg_item;
  logic       take;
  logic       res_fire;
  out_item_t  res_item;
  logic       out_busy;
  logic       sel_sep;

  // register decode
  assign cfg_pready = 1'b1;
  assign sel_sep    = ({cfg_paddr[2], 2'b00} == ADDR_FIELD_SEP) && (cfg_paddr[1:0] == 2'b00
                      || cfg_paddr[1:0] != 2'b00);
  assign cfg_prdata = sel_sep ? {24'd0, field_sep_r} : 32'd0;

  // separator register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_sep_r <= FIELD_SEP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && sel_sep) begin
      field_sep_r <= cfg_pwdata[7:0];
    end
  end

  csvtr_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .take     (take),
    .stg_valid(stg_valid),
    .stg_item (stg_item)
  );

  csvtr_line_core #(
    .SYMBOL_BYTES(SYMBOL_BYTES)
  ) u_line_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .field_sep(field_sep_r),
    .stg_valid(stg_valid),
    .stg_item (stg_item),
    .out_busy (out_busy),
    .take     (take),
    .res_fire (res_fire),
    .res_item (res_item)
  );

  csvtr_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_fire (res_fire),
    .res_item (res_item),
    .out_busy (out_busy),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

/* src/csvtr_in_stage.sv */
// input register stage that holds one byte item until the line core takes it
`timescale 1ns / 1ps

module csvtr_in_stage
  import csvtr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     take,
  output logic     stg_valid,
  output in_item_t stg_item
);

  logic     valid_r;
  in_item_t item_r;

  // hold back the source only while a held item is not taken
  assign in_stall  = valid_r && !take;
  assign stg_valid = valid_r;
  assign stg_item  = item_r;

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_r <= in_data;
    end
  end

endmodule

/* src/csvtr_line_core.sv */
// line state: field splitting, symbol packing, decimal conversion and status
`timescale 1ns / 1ps

module csvtr_line_core
  import csvtr_pkg::*;
#(
  parameter int SYMBOL_BYTES = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic [7:0] field_sep,
  input  logic      stg_valid,
  input  in_item_t  stg_item,
  input  logic      out_busy,
  output logic      take,
  output logic      res_fire,
  output out_item_t res_item
);

  localparam logic [3:0] SymMax = 4'(SYMBOL_BYTES);

  logic [2:0]  field_r,     field_nxt;
  logic [63:0] sym_buf_r,   sym_buf_nxt;
  logic [3:0]  sym_cnt_r,   sym_cnt_nxt;
  logic        sym_ovf_r,   sym_ovf_nxt;
  logic [63:0] mag_r,       mag_nxt;
  logic        minus_r,     minus_nxt;
  logic [1:0]  chars_r,     chars_nxt;
  logic        num_err_r,   num_err_nxt;
  logic [63:0] price_r,     price_nxt;
  logic        price_err_r, price_err_nxt;
  logic        qty_err_r,   qty_err_nxt;
  logic [31:0] qty_r,       qty_nxt;
  logic [7:0]  side_r,      side_nxt;
  logic [1:0]  side_cnt_r,  side_cnt_nxt;

  logic [7:0]  b;
  logic        is_sep;
  logic        is_digit;
  logic [3:0]  digit;
  logic [63:0] mag_step;
  logic        num_ok;
  status_t     stat;

  // the end-of-line byte waits while the result register is full and stalled
  assign take     = stg_valid && !(stg_item.end_of_line && out_busy);
  assign res_fire = take && stg_item.end_of_line;

  assign b        = stg_item.line_byte;
  assign is_sep   = (b == field_sep);
  assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  assign digit    = 4'(b - CHAR_ZERO);
  assign mag_step = {mag_r[60:0], 3'b000} + {mag_r[62:0], 1'b0} + 64'(digit);

  // well formed number within int64, on the field being closed
  always_comb begin
    num_ok = !num_err_r && (chars_r >= (minus_r ? 2'd2 : 2'd1));
    if (!minus_r && (mag_r == MAG_LIMIT)) begin
      num_ok = 1'b0;
    end
  end

  // next line state for one byte
  always_comb begin
    field_nxt     = field_r;
    sym_buf_nxt   = sym_buf_r;
    sym_cnt_nxt   = sym_cnt_r;
    sym_ovf_nxt   = sym_ovf_r;
    mag_nxt       = mag_r;
    minus_nxt     = minus_r;
    chars_nxt     = chars_r;
    num_err_nxt   = num_err_r;
    price_nxt     = price_r;
    price_err_nxt = price_err_r;
    qty_err_nxt   = qty_err_r;
    qty_nxt       = qty_r;
    side_nxt      = side_r;
    side_cnt_nxt  = side_cnt_r;

    if (is_sep) begin
      // separator closes the current field
      if (field_r < FIELD_MAX) begin
        if (field_r == FIELD_PRICE) begin
          price_err_nxt = !num_ok;
          price_nxt     = minus_r ? (64'd0 - mag_r) : mag_r;
        end else if (field_r == FIELD_QTY) begin
          qty_err_nxt = !num_ok || (minus_r && (mag_r != 64'd0));
          qty_nxt     = mag_r[31:0];
        end
        mag_nxt     = '0;
        minus_nxt   = 1'b0;
        chars_nxt   = '0;
        num_err_nxt = 1'b0;
        field_nxt   = field_r + 3'd1;
      end
    end else if (field_r == FIELD_SYMBOL) begin
      // pack symbol bytes, first byte lowest
      if (sym_cnt_r < SymMax) begin
        for (int i = 0; i < 8; i++) begin
          if (sym_cnt_r[2:0] == 3'(i)) begin
            sym_buf_nxt[8*i +: 8] = b;
          end
        end
        sym_cnt_nxt = sym_cnt_r + 4'd1;
      end else begin
        sym_ovf_nxt = 1'b1;
      end
    end else if ((field_r == FIELD_PRICE) || (field_r == FIELD_QTY)) begin
      // decimal digit accumulation with int64 overflow check
      if ((b == CHAR_MINUS) && (chars_r == 2'd0)) begin
        minus_nxt = 1'b1;
      end else if (is_digit) begin
        if (mag_r > digit_limit(digit)) begin
          num_err_nxt = 1'b1;
        end else begin
          mag_nxt = mag_step;
        end
      end else begin
        num_err_nxt = 1'b1;
      end
      if (chars_r < 2'd2) begin
        chars_nxt = chars_r + 2'd1;
      end
    end else if (field_r == FIELD_SIDE) begin
      // side keeps its first byte and counts up to two
      if (side_cnt_r == 2'd0) begin
        side_nxt = b;
      end
      if (side_cnt_r < 2'd2) begin
        side_cnt_nxt = side_cnt_r + 2'd1;
      end
    end
  end

  // status and result from the updated line state
  always_comb begin
    if (field_nxt != FIELD_SIDE) begin
      stat = STAT_FIELDS;
    end else if (price_err_nxt) begin
      stat = STAT_BAD_PRICE;
    end else if (qty_err_nxt) begin
      stat = STAT_BAD_QTY;
    end else if (side_cnt_nxt != 2'd1) begin
      stat = STAT_BAD_SIDE;
    end else if (sym_ovf_nxt) begin
      stat = STAT_SYMBOL_LONG;
    end else begin
      stat = STAT_OK;
    end

    res_item.status        = stat;
    res_item.symbol_text   = sym_buf_nxt;
    res_item.symbol_length = sym_cnt_nxt;
    if ((stat == STAT_OK) || (stat == STAT_SYMBOL_LONG)) begin
      res_item.price_ticks = price_nxt;
      res_item.quantity    = qty_nxt;
      res_item.side_code   = side_nxt;
    end else begin
      res_item.price_ticks = '0;
      res_item.quantity    = '0;
      res_item.side_code   = '0;
    end
  end

  // line state registers, cleared after each line
  always_ff @(posedge clk) begin
    if (!rst_n || res_fire) begin
      field_r     <= '0;
      sym_buf_r   <= '0;
      sym_cnt_r   <= '0;
      sym_ovf_r   <= 1'b0;
      mag_r       <= '0;
      minus_r     <= 1'b0;
      chars_r     <= '0;
      num_err_r   <= 1'b0;
      price_r     <= '0;
      price_err_r <= 1'b0;
      qty_err_r   <= 1'b0;
      qty_r       <= '0;
      side_r      <= '0;
      side_cnt_r  <= '0;
    end else if (take) begin
      field_r     <= field_nxt;
      sym_buf_r   <= sym_buf_nxt;
      sym_cnt_r   <= sym_cnt_nxt;
      sym_ovf_r   <= sym_ovf_nxt;
      mag_r       <= mag_nxt;
      minus_r     <= minus_nxt;
      chars_r     <= chars_nxt;
      num_err_r   <= num_err_nxt;
      price_r     <= price_nxt;
      price_err_r <= price_err_nxt;
      qty_err_r   <= qty_err_nxt;
      qty_r       <= qty_nxt;
      side_r      <= side_nxt;
      side_cnt_r  <= side_cnt_nxt;
    end
  end

endmodule

/* src/csvtr_out_reg.sv */
// result register that holds one line result until the sink takes it
`timescale 1ns / 1ps

module csvtr_out_reg
  import csvtr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_fire,
  input  out_item_t res_item,
  output logic      out_busy,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      valid_r;
  out_item_t data_r;

  // full and not taken this cycle
  assign out_busy  = valid_r && out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_fire) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_fire) begin
      data_r <= res_item;
    end
  end

endmodule

/* bench/tb_csv_trade_record_parser.sv */
// self-checking testbench for the trade record line parser: directed lines, then random lines
`timescale 1ns / 1ps

module tb_csv_trade_record_parser;
  import csvtr_pkg::*;

  localparam int SYM_BYTES     = 8;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BYTES   = 60;
  localparam int PHASE_LINES   = 2;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  // one directed line, with a typed result where it is obvious
  typedef struct {
    string     text;
    bit        typed;
    out_item_t want;
  } line_case_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  in_item_t    in_data     = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  out_item_t   out_data;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  csv_trade_record_parser #(
    .SYMBOL_BYTES(SYM_BYTES)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // clock, 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // line parser state as predicted
  logic [7:0]  sep_now   = FIELD_SEP_RESET;
  logic [2:0]  fld_idx   = '0;
  logic [63:0] sym_buf   = '0;
  logic [3:0]  sym_cnt   = '0;
  bit          sym_long  = 1'b0;
  logic [63:0] mag_acc   = '0;
  bit          minus_on  = 1'b0;
  logic [1:0]  digit_cnt = '0;
  bit          num_bad   = 1'b0;
  logic [63:0] price_val = '0;
  bit          price_bad = 1'b0;
  bit          qty_bad   = 1'b0;
  logic [31:0] qty_val   = '0;
  logic [7:0]  side_val  = '0;
  logic [1:0]  side_cnt  = '0;

  out_item_t   expected_records[$];
  logic [7:0]  line_buf[$];
  line_case_t  cases[$];
  bit          typed_pending = 1'b0;
  out_item_t   typed_record;
  bit          bursty        = 1'b1;
  int          burst_left    = 0;
  int          mismatches    = 0;
  int          cycle_count   = 0;
  stall_mode_t stall_mode    = STALL_NONE;
  int          stall_left    = 0;

  string limit_nums[8] = '{"9223372036854775807", "9223372036854775808",
                           "-9223372036854775808", "-9223372036854775809",
                           "4294967295", "4294967296", "-0", "0"};
  string bad_nums[8]   = '{"", "-", "+5", " 7", "1a", "--1", "1-", "0x1"};

  // append one byte to the line being built
  task automatic append_byte(input logic [7:0] b);
    line_buf.insert(line_buf.size(), b);
  endtask

  // append one record to the expected results
  task automatic append_record(input out_item_t r);
    expected_records.insert(expected_records.size(), r);
  endtask

  task automatic clear_line_state();
    fld_idx   = '0;
    sym_buf   = '0;
    sym_cnt   = '0;
    sym_long  = 1'b0;
    mag_acc   = '0;
    minus_on  = 1'b0;
    digit_cnt = '0;
    num_bad   = 1'b0;
    price_val = '0;
    price_bad = 1'b0;
    qty_bad   = 1'b0;
    qty_val   = '0;
    side_val  = '0;
    side_cnt  = '0;
  endtask

  // strict int64 number: optional minus, at least one digit, in range
  function automatic bit number_well_formed();
    if (num_bad) return 1'b0;
    if (digit_cnt < (minus_on ? 2'd2 : 2'd1)) return 1'b0;
    if (!minus_on && mag_acc == MAG_LIMIT) return 1'b0;
    return 1'b1;
  endfunction

  // advance the predicted line state by one byte, giving a record at end of line
  task automatic parse_trade_byte(input logic [7:0] b, input bit eol,
                                  output bit done, output out_item_t rec);
    logic [63:0] d;
    bit          ok;
    done = 1'b0;
    rec  = '0;
    if (b == sep_now) begin
      // separator closes the open field, ignored past the fourth
      if (fld_idx < FIELD_MAX) begin
        ok = number_well_formed();
        if (fld_idx == FIELD_PRICE) begin
          price_bad = !ok;
          price_val = minus_on ? 64'd0 - mag_acc : mag_acc;
        end else if (fld_idx == FIELD_QTY) begin
          qty_bad = !ok || (minus_on && mag_acc != 64'd0);
          qty_val = mag_acc[31:0];
        end
        mag_acc   = '0;
        minus_on  = 1'b0;
        digit_cnt = '0;
        num_bad   = 1'b0;
        fld_idx++;
      end
    end else if (fld_idx == FIELD_SYMBOL) begin
      if (sym_cnt < SYM_BYTES) begin
        sym_buf[8*sym_cnt +: 8] = b;
        sym_cnt++;
      end else begin
        sym_long = 1'b1;
      end
    end else if (fld_idx == FIELD_PRICE || fld_idx == FIELD_QTY) begin
      // decimal accumulate with int64 magnitude guard
      if (b == CHAR_MINUS && digit_cnt == 0) begin
        minus_on = 1'b1;
      end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
        d = 64'(b) - 64'(CHAR_ZERO);
        if (mag_acc > (MAG_LIMIT - d) / 64'd10) begin
          num_bad = 1'b1;
        end else begin
          mag_acc = mag_acc * 64'd10 + d;
        end
      end else begin
        num_bad = 1'b1;
      end
      if (digit_cnt < 2) digit_cnt++;
    end else if (fld_idx == FIELD_SIDE) begin
      if (side_cnt == 0) side_val = b;
      if (side_cnt < 2) side_cnt++;
    end

    if (eol) begin
      if (fld_idx != FIELD_SIDE) rec.status = STAT_FIELDS;
      else if (price_bad) rec.status = STAT_BAD_PRICE;
      else if (qty_bad) rec.status = STAT_BAD_QTY;
      else if (side_cnt != 1) rec.status = STAT_BAD_SIDE;
      else if (sym_long) rec.status = STAT_SYMBOL_LONG;
      else rec.status = STAT_OK;
      rec.symbol_text   = sym_buf;
      rec.symbol_length = sym_cnt;
      if (rec.status == STAT_OK || rec.status == STAT_SYMBOL_LONG) begin
        rec.price_ticks = price_val;
        rec.quantity    = qty_val;
        rec.side_code   = side_val;
      end
      done = 1'b1;
      clear_line_state();
    end
  endtask

  function automatic out_item_t rec_of(status_t st, logic [63:0] sym, logic [3:0] len,
                                       logic [63:0] px, logic [31:0] q, logic [7:0] sd);
    out_item_t r;
    r.status        = st;
    r.symbol_text   = sym;
    r.symbol_length = len;
    r.price_ticks   = px;
    r.quantity      = q;
    r.side_code     = sd;
    return r;
  endfunction

  // compare one result item with the oldest expected record
  task automatic check_record(input out_item_t got);
    out_item_t want;
    if (expected_records.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result at %0t: st=%0d sym=%h len=%0d", $time,
                 got.status, got.symbol_text, got.symbol_length);
    end else begin
      want = expected_records.pop_front();
      if (got.status !== want.status || got.symbol_text !== want.symbol_text ||
          got.symbol_length !== want.symbol_length ||
          got.price_ticks !== want.price_ticks || got.quantity !== want.quantity ||
          got.side_code !== want.side_code) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t: expected st=%0d sym=%h len=%0d px=%0d qty=%0d side=%h",
                   $time, want.status, want.symbol_text, want.symbol_length,
                   want.price_ticks, want.quantity, want.side_code);
          $display("                 actual   st=%0d sym=%h len=%0d px=%0d qty=%0d side=%h",
                   got.status, got.symbol_text, got.symbol_length,
                   got.price_ticks, got.quantity, got.side_code);
        end
      end
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_record(out_data);
  end

  // receiver stall pattern, changing mode every so often
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        stall_left <= $urandom_range(20, 150);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 4) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ~out_stall;
      endcase
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // send one byte item, with bursts and gaps on the sender side
  task automatic send_byte(input logic [7:0] b, input bit eol);
    bit        done;
    out_item_t rec;
    if (bursty && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_data  <= '{line_byte: b, end_of_line: eol};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    parse_trade_byte(b, eol, done, rec);
    if (done) append_record(typed_pending ? typed_record : rec);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) begin
      send_byte(line_buf[i], i == line_buf.size() - 1);
    end
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endtask

  // mostly letters, sometimes any byte, never the separator
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    if ($urandom_range(0, 3) != 0) b = 8'h41 + 8'($urandom_range(0, 25));
    else b = 8'($urandom());
    if (b == sep_now) b = ~b;
    return b;
  endfunction

  task automatic put_number(input bit for_qty);
    int pick;
    int len;
    pick = $urandom_range(0, 11);
    if (pick == 0) begin
      put_str(limit_nums[$urandom_range(0, 7)]);
    end else if (pick == 1) begin
      put_str(bad_nums[$urandom_range(0, 7)]);
    end else begin
      if ($urandom_range(0, 99) < (for_qty ? 10 : 30)) append_byte(CHAR_MINUS);
      if (pick == 2) len = $urandom_range(19, 22);
      else if ($urandom_range(0, 1) != 0) len = $urandom_range(1, 4);
      else len = $urandom_range(1, 18);
      repeat (len) append_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  // random line: mostly well-formed records, some broken, some noise
  task automatic build_random_line();
    int shape;
    int n;
    int pos;
    line_buf.delete();
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      n = $urandom_range(1, 24);
      repeat (n) append_byte(($urandom_range(0, 4) == 0) ? sep_now : 8'($urandom()));
    end else begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : $urandom_range(1, SYM_BYTES);
      repeat (n) append_byte(text_byte());
      append_byte(sep_now);
      put_number(1'b0);
      append_byte(sep_now);
      put_number(1'b1);
      append_byte(sep_now);
      // side: usually one byte, now and then empty or two bytes
      n = $urandom_range(0, 15);
      if (n != 0) append_byte(text_byte());
      if (n == 1) append_byte(text_byte());
      if (shape == 1) begin
        pos = $urandom_range(0, line_buf.size() - 1);
        case ($urandom_range(0, 2))
          0: line_buf.delete(pos);
          1: line_buf.insert(pos, 8'($urandom()));
          default: begin
            append_byte(sep_now);
            append_byte(text_byte());
          end
        endcase
      end
    end
  endtask

  task automatic wait_idle();
    while (expected_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_sep_readback();
    logic [31:0] got;
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_paddr   <= ADDR_FIELD_SEP;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== {24'd0, sep_now}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("separator readback at %0t: expected %h actual %h", $time,
                 {24'd0, sep_now}, got);
    end
  endtask

  // write the separator with junk in the unused upper bits, then read it back
  task automatic write_sep(input logic [7:0] v);
    logic [31:0] junk;
    junk = $urandom();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= ADDR_FIELD_SEP;
    cfg_pwdata  <= {junk[31:8], v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sep_now = v;
    @(posedge clk);
    check_sep_readback();
  endtask

  task automatic add_case(input string text, input bit typed, input out_item_t want);
    line_case_t c;
    c.text  = text;
    c.typed = typed;
    c.want  = want;
    cases.insert(cases.size(), c);
  endtask

  initial begin
    logic [7:0] phase_sep[5];
    logic [7:0] rnd_sep;
    int         sent;
    int         lines;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    clear_line_state();
    check_sep_readback();

    // directed lines with the reset separator
    add_case("Z", 1, rec_of(STAT_FIELDS, 64'h5a, 1, 0, 0, 0));
    add_case("AB,1,2,B", 1, rec_of(STAT_OK, 64'h4241, 2, 1, 2, 8'h42));
    add_case("S,9223372036854775807,4294967295,B", 1,
             rec_of(STAT_OK, 64'h53, 1, 64'h7fff_ffff_ffff_ffff, 32'hffff_ffff, 8'h42));
    add_case("S,-9223372036854775808,0,S", 1,
             rec_of(STAT_OK, 64'h53, 1, 64'h8000_0000_0000_0000, 0, 8'h53));
    add_case("S,9223372036854775808,1,B", 1, rec_of(STAT_BAD_PRICE, 64'h53, 1, 0, 0, 0));
    add_case("S,-9223372036854775809,1,B", 1, rec_of(STAT_BAD_PRICE, 64'h53, 1, 0, 0, 0));
    add_case("S,1,-1,B", 1, rec_of(STAT_BAD_QTY, 64'h53, 1, 0, 0, 0));
    add_case("S,1,1,BS", 1, rec_of(STAT_BAD_SIDE, 64'h53, 1, 0, 0, 0));
    add_case("S,1,1,", 1, rec_of(STAT_BAD_SIDE, 64'h53, 1, 0, 0, 0));
    add_case("ABCDEFGHI,7,3,S", 1,
             rec_of(STAT_SYMBOL_LONG, 64'h4847_4645_4443_4241, 8, 7, 3, 8'h53));
    add_case("S,1,1,B,X", 1, rec_of(STAT_FIELDS, 64'h53, 1, 0, 0, 0));
    add_case("S,-0,-0,B", 1, rec_of(STAT_OK, 64'h53, 1, 0, 0, 8'h42));
    add_case("S,+1,1,B", 1, rec_of(STAT_BAD_PRICE, 64'h53, 1, 0, 0, 0));
    add_case("S,,1,B", 1, rec_of(STAT_BAD_PRICE, 64'h53, 1, 0, 0, 0));
    add_case("S,-,1,B", 1, rec_of(STAT_BAD_PRICE, 64'h53, 1, 0, 0, 0));
    add_case("S,1,,B", 1, rec_of(STAT_BAD_QTY, 64'h53, 1, 0, 0, 0));
    add_case(",1,1,B", 1, rec_of(STAT_OK, 0, 0, 1, 1, 8'h42));
    add_case("S,1,4294967296,B", 0, '0);
    add_case("S, 1,99999999999999999999,B", 0, '0);
    add_case("ABCDEFGH,-42,12345678901,\377", 0, '0);
    add_case("\377\200,00012,-0,s", 0, '0);
    add_case("S,1,1,B,,,", 0, '0);

    bursty = 1'b1;
    foreach (cases[i]) begin
      line_buf.delete();
      put_str(cases[i].text);
      typed_pending = cases[i].typed;
      typed_record  = cases[i].want;
      send_line();
      typed_pending = 1'b0;
    end
    in_valid <= 1'b0;
    wait_idle();

    // random phases, separator extremes among them
    do rnd_sep = 8'($urandom());
    while ((rnd_sep >= CHAR_ZERO && rnd_sep <= CHAR_NINE) || rnd_sep == CHAR_MINUS);
    phase_sep = '{8'h00, 8'hff, 8'h7c, rnd_sep, FIELD_SEP_RESET};
    foreach (phase_sep[p]) begin
      write_sep(phase_sep[p]);
      bursty = ($urandom_range(0, 2) != 0);
      sent   = 0;
      lines  = 0;
      while (sent < PHASE_BYTES || lines < PHASE_LINES) begin
        build_random_line();
        sent += line_buf.size();
        lines++;
        send_line();
      end
      in_valid <= 1'b0;
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* csv_trade_record_parser.f */
src/csvtr_pkg.sv
src/csvtr_in_stage.sv
src/csvtr_line_core.sv
src/csvtr_out_reg.sv
src/csv_trade_record_parser.sv
bench/tb_csv_trade_record_parser.sv
